// ===== rtl/ecr_pkg.sv =====
// ----------------------------------------------------------------------------
// ecr_pkg
// Shared constants and word types of the elastic collision resolver.
// ----------------------------------------------------------------------------
package ecr_pkg;

	localparam int FRAC_BITS = 16;

	localparam logic [1:0] OUT_NONE       = 2'd0;
	localparam logic [1:0] OUT_REST       = 2'd1;
	localparam logic [1:0] OUT_RESOLVED   = 2'd2;
	localparam logic [1:0] OUT_COINCIDENT = 2'd3;

	typedef struct packed {
		logic signed [31:0] first_pos_x;
		logic signed [31:0] first_pos_y;
		logic signed [31:0] first_vel_x;
		logic signed [31:0] first_vel_y;
		logic [30:0]        first_radius;
		logic [15:0]        first_mass;
		logic signed [31:0] second_pos_x;
		logic signed [31:0] second_pos_y;
		logic signed [31:0] second_vel_x;
		logic signed [31:0] second_vel_y;
		logic [30:0]        second_radius;
		logic [15:0]        second_mass;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] new_first_vel_x;
		logic signed [31:0] new_first_vel_y;
		logic signed [31:0] new_second_vel_x;
		logic signed [31:0] new_second_vel_y;
		logic [1:0]         outcome;
	} out_word_t;

endpackage

// ===== rtl/elastic_collision_resolver.sv =====
// Throughput: one word per cycle while out_ready does not stall a full pipeline; the depth
// is set by the 32-step square root (two steps a stage) and the two restoring dividers that
// follow it.
// Reset: arst_n clears all valid bits and the output flag; still_sq_q returns
// to 1. The data path registers are not reset.
// ----------------------------------------------------------------------------
// elastic_collision_resolver
// Pipelined 2-D elastic collision of two disks in fixed point: overlap and
// rest checks, normal from an integer square root, mass formula, saturation.
// ----------------------------------------------------------------------------
module elastic_collision_resolver import ecr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_word_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_word_t   out_data
);

	localparam int SQ_STEPS = 32;
	localparam int SQ_PER   = 2;
	localparam int SQ_ST    = SQ_STEPS / SQ_PER;
	localparam int U_STEPS  = FRAC_BITS + 1;
	localparam int U_PER    = 2;
	localparam int U_ST     = (U_STEPS + U_PER - 1) / U_PER;
	localparam int DVW      = 31 + FRAC_BITS + 1;
	localparam int UW       = FRAC_BITS + 2;
	localparam int PW       = UW + 32;
	localparam int VW       = 35;
	localparam int MD       = 17;
	localparam int MQ       = 35;
	localparam int M_PER    = 4;
	localparam int M_ST     = (MQ + M_PER - 1) / M_PER;
	localparam int MW       = VW + MD + 1;
	localparam int NW       = MW + 1;
	localparam int FW       = MQ + 1;
	localparam int RW       = FW + UW;

	localparam int ST_IN    = 0;
	localparam int ST_REST  = ST_IN + 1;
	localparam int ST_NSUM  = ST_REST + 1;
	localparam int ST_ROOT  = ST_NSUM + 1;
	localparam int ST_UINIT = ST_ROOT + SQ_ST;
	localparam int ST_UDIV  = ST_UINIT + 1;
	localparam int ST_DOT   = ST_UDIV + U_ST;
	localparam int ST_DSUM  = ST_DOT + 1;
	localparam int ST_MMUL  = ST_DSUM + 1;
	localparam int ST_MINIT = ST_MMUL + 1;
	localparam int ST_MDIV  = ST_MINIT + 1;
	localparam int ST_RMUL  = ST_MDIV + M_ST;
	localparam int ST_OUT   = ST_RMUL + 1;
	localparam int NST      = ST_OUT + 1;

	localparam logic signed [PW:0] RND_D = (PW + 1)'(1) << (FRAC_BITS - 1);
	localparam logic signed [RW:0] RND_R = (RW + 1)'(1) << (FRAC_BITS - 1);
	localparam logic signed [RW:0] SMAX  = (RW + 1)'(32'h7FFF_FFFF);
	localparam logic signed [RW:0] SMIN  = ~SMAX;

	typedef struct packed {
		logic signed [31:0]    v1x, v1y, v2x, v2y;
		logic [15:0]           m1, m2;
		logic [1:0]            outcome;
		logic                  ovl, zro, sgx, sgy;
		logic [32:0]           adx, ady;
		logic [63:0]           vq0, vq1, vq2, vq3;
		logic [30:0]           ahx, ahy;
		logic [61:0]           ax2, ay2;
		logic [63:0]           sq_n, sq_r;
		logic [31:0]           len;
		logic [31:0]           remx, remy;
		logic [U_STEPS-1:0]    qx, qy;
		logic signed [UW-1:0]  ux, uy;
		logic signed [PW-1:0]  pd0, pd1, pd2, pd3, pd4, pd5, pd6, pd7;
		logic signed [VW-1:0]  v1n, v1t, v2n, v2t;
		logic [MD-1:0]         msum;
		logic signed [MW-1:0]  ma1, mb1, ma2, mb2;
		logic                  neg1, neg2, msum0;
		logic [MD-1:0]         rem1, rem2;
		logic [MQ-1:0]         q1, q2;
		logic signed [RW-1:0]  rp0, rp1, rp2, rp3, rp4, rp5, rp6, rp7;
		logic signed [31:0]    n1x, n1y, n2x, n2y;
	} ctx_t;

	function automatic logic [127:0] root_step(input logic [63:0] n, input logic [63:0] r,
		input int k);
		logic [63:0] b, t, nn, rr;
		b = 64'd1 << (2 * (SQ_STEPS - 1 - k));
		t = r + b;
		if (n >= t) begin
			nn = n - t;
			rr = (r >> 1) + b;
		end else begin
			nn = n;
			rr = r >> 1;
		end
		return {nn, rr};
	endfunction

	function automatic logic [32+U_STEPS-1:0] udiv_step(input logic [31:0] rem,
		input logic [U_STEPS-1:0] q, input logic [31:0] d);
		logic [32:0] t;
		logic [31:0] nr;
		logic [U_STEPS-1:0] nq;
		t  = {rem, q[U_STEPS-1]};
		nq = {q[U_STEPS-2:0], 1'b0};
		if (t >= {1'b0, d}) begin
			nr    = 32'(t - {1'b0, d});
			nq[0] = 1'b1;
		end else begin
			nr = t[31:0];
		end
		return {nr, nq};
	endfunction

	function automatic logic [MD+MQ-1:0] mdiv_step(input logic [MD-1:0] rem,
		input logic [MQ-1:0] q, input logic [MD-1:0] d);
		logic [MD:0] t;
		logic [MD-1:0] nr;
		logic [MQ-1:0] nq;
		t  = {rem, q[MQ-1]};
		nq = {q[MQ-2:0], 1'b0};
		if (t >= {1'b0, d}) begin
			nr    = MD'(t - {1'b0, d});
			nq[0] = 1'b1;
		end else begin
			nr = t[MD-1:0];
		end
		return {nr, nq};
	endfunction

	function automatic logic signed [31:0] sat_round(input logic signed [RW-1:0] a,
		input logic signed [RW-1:0] b);
		logic signed [RW:0] s;
		s = (RW + 1)'(a);
		s = s + b + RND_R;
		s = s >>> FRAC_BITS;
		if (s > SMAX) begin
			return SMAX[31:0];
		end else if (s < SMIN) begin
			return SMIN[31:0];
		end
		return s[31:0];
	endfunction

	logic [31:0]    still_sq_q;
	logic [NST-1:0] vld_s;
	ctx_t           ctx_s [NST];
	ctx_t           nxt [NST];
	logic           adv;
	logic           out_valid_q;
	out_word_t      out_data_q;

	assign cfg_ready = 1'b1;
	assign adv       = !vld_s[NST-1] || !out_valid_q || out_ready;
	assign in_ready  = adv;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			still_sq_q <= 32'd1;
		end else if (cfg_valid) begin
			still_sq_q <= cfg_data * cfg_data;
		end
	end

	always_comb begin
		ctx_t c;
		logic signed [32:0] dx, dy;
		logic [31:0] rs, a1x, a1y, a2x, a2y;
		logic [64:0] e1, e2;
		logic rest, hv;
		logic [63:0] rn, rr;
		logic [31:0] ur;
		logic [U_STEPS-1:0] uq;
		logic [DVW-1:0] dvx, dvy;
		logic signed [UW-1:0] ux, uy, tx;
		logic signed [PW:0] sa;
		logic signed [MD-1:0] dm1;
		logic signed [MD:0] tw1, tw2;
		logic signed [NW-1:0] num1, num2;
		logic [NW-1:0] mg1, mg2;
		logic [MD-1:0] mr;
		logic [MQ-1:0] mq;
		logic signed [FW-1:0] f1, f2;
		int s;
		int k;

		// front stage: differences, overlap, speed squares
		c = '0;
		dx = 33'(in_data.second_pos_x) - 33'(in_data.first_pos_x);
		dy = 33'(in_data.second_pos_y) - 33'(in_data.first_pos_y);
		c.adx = dx[32] ? 33'(-dx) : 33'(dx);
		c.ady = dy[32] ? 33'(-dy) : 33'(dy);
		c.sgx = dx[32];
		c.sgy = dy[32];
		c.zro = (dx == '0) && (dy == '0);
		rs = 32'(in_data.first_radius) + 32'(in_data.second_radius);
		c.ovl = (c.adx < {1'b0, rs}) && (c.ady < {1'b0, rs});
		c.v1x = in_data.first_vel_x;
		c.v1y = in_data.first_vel_y;
		c.v2x = in_data.second_vel_x;
		c.v2y = in_data.second_vel_y;
		c.m1 = in_data.first_mass;
		c.m2 = in_data.second_mass;
		a1x = c.v1x[31] ? 32'(-c.v1x) : 32'(c.v1x);
		a1y = c.v1y[31] ? 32'(-c.v1y) : 32'(c.v1y);
		a2x = c.v2x[31] ? 32'(-c.v2x) : 32'(c.v2x);
		a2y = c.v2y[31] ? 32'(-c.v2y) : 32'(c.v2y);
		c.vq0 = a1x * a1x;
		c.vq1 = a1y * a1y;
		c.vq2 = a2x * a2x;
		c.vq3 = a2y * a2y;
		nxt[ST_IN] = c;

		for (int g = 1; g < NST; g++) begin
			c = ctx_s[g-1];
			if (g == ST_REST) begin
				e1 = 65'(c.vq0) + 65'(c.vq1);
				e2 = 65'(c.vq2) + 65'(c.vq3);
				rest = (e1 < 65'(still_sq_q)) && (e2 < 65'(still_sq_q));
				if (!c.ovl) begin
					c.outcome = OUT_NONE;
				end else if (rest) begin
					c.outcome = OUT_REST;
				end else if (c.zro) begin
					c.outcome = OUT_COINCIDENT;
				end else begin
					c.outcome = OUT_RESOLVED;
				end
				// halve both offsets when either reaches 2^31
				hv = (c.adx[32:31] != 2'b00) || (c.ady[32:31] != 2'b00);
				c.ahx = hv ? c.adx[31:1] : c.adx[30:0];
				c.ahy = hv ? c.ady[31:1] : c.ady[30:0];
				c.ax2 = c.ahx * c.ahx;
				c.ay2 = c.ahy * c.ahy;
			end else if (g == ST_NSUM) begin
				c.sq_n = 64'(c.ax2) + 64'(c.ay2);
				c.sq_r = '0;
			end else if (g >= ST_ROOT && g < ST_UINIT) begin
				s = g - ST_ROOT;
				rn = c.sq_n;
				rr = c.sq_r;
				for (int j = 0; j < SQ_PER; j++) begin
					k = s * SQ_PER + j;
					{rn, rr} = root_step(rn, rr, k);
				end
				c.sq_n = rn;
				c.sq_r = rr;
			end else if (g == ST_UINIT) begin
				c.len = c.sq_r[31:0];
				dvx = DVW'({c.ahx, {FRAC_BITS{1'b0}}}) + DVW'(c.len >> 1);
				dvy = DVW'({c.ahy, {FRAC_BITS{1'b0}}}) + DVW'(c.len >> 1);
				c.remx = 32'(dvx[DVW-1:U_STEPS]);
				c.remy = 32'(dvy[DVW-1:U_STEPS]);
				c.qx = dvx[U_STEPS-1:0];
				c.qy = dvy[U_STEPS-1:0];
			end else if (g >= ST_UDIV && g < ST_DOT) begin
				s = g - ST_UDIV;
				for (int j = 0; j < U_PER; j++) begin
					k = s * U_PER + j;
					if (k < U_STEPS) begin
						{ur, uq} = udiv_step(c.remx, c.qx, c.len);
						c.remx = ur;
						c.qx = uq;
						{ur, uq} = udiv_step(c.remy, c.qy, c.len);
						c.remy = ur;
						c.qy = uq;
					end
				end
			end else if (g == ST_DOT) begin
				ux = c.sgx ? -$signed({1'b0, c.qx}) : $signed({1'b0, c.qx});
				uy = c.sgy ? -$signed({1'b0, c.qy}) : $signed({1'b0, c.qy});
				tx = -uy;
				c.ux = ux;
				c.uy = uy;
				c.pd0 = ux * c.v1x;
				c.pd1 = uy * c.v1y;
				c.pd2 = tx * c.v1x;
				c.pd3 = ux * c.v1y;
				c.pd4 = ux * c.v2x;
				c.pd5 = uy * c.v2y;
				c.pd6 = tx * c.v2x;
				c.pd7 = ux * c.v2y;
			end else if (g == ST_DSUM) begin
				sa = (PW + 1)'(c.pd0);
				sa = sa + c.pd1 + RND_D;
				c.v1n = VW'(sa >>> FRAC_BITS);
				sa = (PW + 1)'(c.pd2);
				sa = sa + c.pd3 + RND_D;
				c.v1t = VW'(sa >>> FRAC_BITS);
				sa = (PW + 1)'(c.pd4);
				sa = sa + c.pd5 + RND_D;
				c.v2n = VW'(sa >>> FRAC_BITS);
				sa = (PW + 1)'(c.pd6);
				sa = sa + c.pd7 + RND_D;
				c.v2t = VW'(sa >>> FRAC_BITS);
			end else if (g == ST_MMUL) begin
				dm1 = $signed({1'b0, c.m1}) - $signed({1'b0, c.m2});
				tw1 = $signed({1'b0, c.m1, 1'b0});
				tw2 = $signed({1'b0, c.m2, 1'b0});
				c.msum = MD'(c.m1) + MD'(c.m2);
				c.ma1 = c.v1n * dm1;
				c.mb1 = c.v2n * tw2;
				c.ma2 = c.v2n * (-dm1);
				c.mb2 = c.v1n * tw1;
			end else if (g == ST_MINIT) begin
				num1 = NW'(c.ma1);
				num1 = num1 + c.mb1;
				num2 = NW'(c.ma2);
				num2 = num2 + c.mb2;
				c.neg1 = num1[NW-1];
				c.neg2 = num2[NW-1];
				mg1 = c.neg1 ? NW'(-num1) : NW'(num1);
				mg2 = c.neg2 ? NW'(-num2) : NW'(num2);
				mg1 = mg1 + NW'(c.msum >> 1);
				mg2 = mg2 + NW'(c.msum >> 1);
				c.msum0 = (c.msum == '0);
				c.rem1 = MD'(mg1 >> MQ);
				c.rem2 = MD'(mg2 >> MQ);
				c.q1 = mg1[MQ-1:0];
				c.q2 = mg2[MQ-1:0];
			end else if (g >= ST_MDIV && g < ST_RMUL) begin
				s = g - ST_MDIV;
				for (int j = 0; j < M_PER; j++) begin
					k = s * M_PER + j;
					if (k < MQ) begin
						{mr, mq} = mdiv_step(c.rem1, c.q1, c.msum);
						c.rem1 = mr;
						c.q1 = mq;
						{mr, mq} = mdiv_step(c.rem2, c.q2, c.msum);
						c.rem2 = mr;
						c.q2 = mq;
					end
				end
			end else if (g == ST_RMUL) begin
				// both masses zero: keep the normal parts
				if (c.msum0) begin
					f1 = FW'(c.v1n);
					f2 = FW'(c.v2n);
				end else begin
					f1 = c.neg1 ? -$signed({1'b0, c.q1}) : $signed({1'b0, c.q1});
					f2 = c.neg2 ? -$signed({1'b0, c.q2}) : $signed({1'b0, c.q2});
				end
				tx = -c.uy;
				c.rp0 = f1 * c.ux;
				c.rp1 = c.v1t * tx;
				c.rp2 = f1 * c.uy;
				c.rp3 = c.v1t * c.ux;
				c.rp4 = f2 * c.ux;
				c.rp5 = c.v2t * tx;
				c.rp6 = f2 * c.uy;
				c.rp7 = c.v2t * c.ux;
			end else if (g == ST_OUT) begin
				if (c.outcome == OUT_RESOLVED) begin
					c.n1x = sat_round(c.rp0, c.rp1);
					c.n1y = sat_round(c.rp2, c.rp3);
					c.n2x = sat_round(c.rp4, c.rp5);
					c.n2y = sat_round(c.rp6, c.rp7);
				end else begin
					c.n1x = c.v1x;
					c.n1y = c.v1y;
					c.n2x = c.v2x;
					c.n2y = c.v2y;
				end
			end
			nxt[g] = c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[NST-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int g = 0; g < NST; g++) begin
				ctx_s[g] <= nxt[g];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && vld_s[NST-1]) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld_s[NST-1]) begin
			out_data_q.new_first_vel_x  <= ctx_s[NST-1].n1x;
			out_data_q.new_first_vel_y  <= ctx_s[NST-1].n1y;
			out_data_q.new_second_vel_x <= ctx_s[NST-1].n2x;
			out_data_q.new_second_vel_y <= ctx_s[NST-1].n2y;
			out_data_q.outcome          <= ctx_s[NST-1].outcome;
		end
	end

`ifndef SYNTHESIS
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |=> vld_s[NST-1])
		else $error("stalled pipeline lost its last word");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !vld_s[NST-1] |=> !out_valid)
		else $error("output word repeated after it was taken");

	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[ST_UINIT] && ctx_s[ST_UINIT].outcome == OUT_RESOLVED
		|-> ctx_s[ST_UINIT].len != '0)
		else $error("zero center distance on a resolved pair");
`endif

endmodule
